[hw/rtl/file_protocol_reply_parser_assert.svh]
// Assertion macros shared by the reply parser modules.
// Included by frp_parser and frp_result_queue; needs nothing else.
`ifndef FILE_PROTOCOL_REPLY_PARSER_ASSERT_SVH
`define FILE_PROTOCOL_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FRP_ASSERT_NOW(label, clk, rst_n, cond, impl, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (impl)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FRP_ASSERT_NEXT(label, clk, rst_n, cond, impl, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (impl)) \
        else $error(msg);

`endif

[hw/rtl/frp_pkg.sv]
// Types and constants for the 9P reply parser.
// Standalone; used by the parser, the result queue and the top level.
`default_nettype none

package frp_pkg;

    // event codes
    localparam logic [3:0] EV_HEADER   = 4'd0;
    localparam logic [3:0] EV_MSIZE    = 4'd1;
    localparam logic [3:0] EV_STRLEN   = 4'd2;
    localparam logic [3:0] EV_STRBYTE  = 4'd3;
    localparam logic [3:0] EV_QID      = 4'd4;
    localparam logic [3:0] EV_IOUNIT   = 4'd5;
    localparam logic [3:0] EV_COUNT    = 4'd6;
    localparam logic [3:0] EV_DATABYTE = 4'd7;
    localparam logic [3:0] EV_NWQID    = 4'd8;
    localparam logic [3:0] EV_DONE     = 4'd9;

    // message kinds
    localparam logic [3:0] KIND_UNKNOWN = 4'd0;
    localparam logic [3:0] KIND_VERSION = 4'd1;
    localparam logic [3:0] KIND_ATTACH  = 4'd2;
    localparam logic [3:0] KIND_ERROR   = 4'd3;
    localparam logic [3:0] KIND_WALK    = 4'd4;
    localparam logic [3:0] KIND_OPEN    = 4'd5;
    localparam logic [3:0] KIND_READ    = 4'd6;
    localparam logic [3:0] KIND_WRITE   = 4'd7;
    localparam logic [3:0] KIND_CLUNK   = 4'd8;

    // done status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_SIZE        = 4'd2;
    localparam logic [3:0] ST_MSIZE       = 4'd3;
    localparam logic [3:0] ST_VERSION     = 4'd4;
    localparam logic [3:0] ST_ATTACH_QID  = 4'd5;
    localparam logic [3:0] ST_ENAME       = 4'd6;
    localparam logic [3:0] ST_WALK_COUNT  = 4'd7;
    localparam logic [3:0] ST_WALK_QID    = 4'd8;
    localparam logic [3:0] ST_OPEN_QID    = 4'd9;
    localparam logic [3:0] ST_IOUNIT      = 4'd10;
    localparam logic [3:0] ST_READ_COUNT  = 4'd11;
    localparam logic [3:0] ST_READ_DATA   = 4'd12;
    localparam logic [3:0] ST_WRITE_COUNT = 4'd13;
    localparam logic [3:0] ST_UNKNOWN     = 4'd14;

    // reply type bytes
    localparam logic [7:0] TY_VERSION = 8'd101;
    localparam logic [7:0] TY_ATTACH  = 8'd105;
    localparam logic [7:0] TY_ERROR   = 8'd107;
    localparam logic [7:0] TY_WALK    = 8'd111;
    localparam logic [7:0] TY_OPEN    = 8'd113;
    localparam logic [7:0] TY_READ    = 8'd117;
    localparam logic [7:0] TY_WRITE   = 8'd119;
    localparam logic [7:0] TY_CLUNK   = 8'd121;

    // field lengths in bytes
    localparam int unsigned HDR_LEN = 7;
    localparam int unsigned QID_LEN = 13;
    localparam int unsigned U32_LEN = 4;
    localparam int unsigned U16_LEN = 2;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [3:0]  msg_kind;
        logic [63:0] value;
        logic [7:0]  qid_type;
        logic [31:0] qid_version;
        logic [3:0]  status;
        logic        last_of_run;
    } frp_result_t;

    // up to two results per byte; r0 goes out first
    typedef struct packed {
        logic [1:0]  cnt;
        frp_result_t r0;
        frp_result_t r1;
    } frp_push_t;

    function automatic logic [3:0] frp_kind_of(logic [7:0] ty);
        logic [3:0] k;
        case (ty)
            TY_VERSION: k = KIND_VERSION;
            TY_ATTACH:  k = KIND_ATTACH;
            TY_ERROR:   k = KIND_ERROR;
            TY_WALK:    k = KIND_WALK;
            TY_OPEN:    k = KIND_OPEN;
            TY_READ:    k = KIND_READ;
            TY_WRITE:   k = KIND_WRITE;
            TY_CLUNK:   k = KIND_CLUNK;
            default:    k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/frp_byte_if.sv]
// Byte request channel into the reply parser: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface frp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_message;

    modport source (output valid, output rx_byte, output end_of_message, input ready);
    modport sink   (input valid, input rx_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

[hw/rtl/frp_event_if.sv]
// Event request channel out of the reply parser: valid/ready plus payload.
// No dependencies.
`default_nettype none

interface frp_event_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [3:0]  msg_kind;
    logic [63:0] value;
    logic [7:0]  qid_type;
    logic [31:0] qid_version;
    logic [3:0]  status;
    logic        last_of_run;

    modport source (output valid, output event_res, output msg_kind, output value,
                    output qid_type, output qid_version, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_res, input msg_kind, input value,
                    input qid_type, input qid_version, input status,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/frp_parser.sv]
// Per-byte 9P reply field decoder: parse state registers and next-state logic.
// Depends on frp_pkg, frp_byte_if and the assertion macro header.
`default_nettype none
`include "file_protocol_reply_parser_assert.svh"

module frp_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    frp_byte_if.sink          msg,
    input  wire logic         room,
    output frp_pkg::frp_push_t push
);
    import frp_pkg::*;

    localparam logic [3:0] PH_HDR      = 4'd0;
    localparam logic [3:0] PH_MSIZE    = 4'd1;
    localparam logic [3:0] PH_STRLEN   = 4'd2;
    localparam logic [3:0] PH_STRBYTES = 4'd3;
    localparam logic [3:0] PH_QID      = 4'd4;
    localparam logic [3:0] PH_NWQID    = 4'd5;
    localparam logic [3:0] PH_IOUNIT   = 4'd6;
    localparam logic [3:0] PH_COUNT    = 4'd7;
    localparam logic [3:0] PH_DATA     = 4'd8;
    localparam logic [3:0] PH_TAIL     = 4'd9;
    localparam logic [3:0] PH_SKIP     = 4'd10;

    logic [31:0] bc_reg,    bc_next;
    logic [31:0] ds_reg,    ds_next;
    logic [7:0]  type_reg,  type_next;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  fbi_reg,   fbi_next;
    logic [63:0] acc_reg,   acc_next;
    logic [7:0]  hqt_reg,   hqt_next;
    logic [31:0] hqv_reg,   hqv_next;
    logic [31:0] br_reg,    br_next;
    logic [15:0] qr_reg,    qr_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] bc_inc;
    logic [3:0]  fbi_inc;
    logic [63:0] byte_acc;
    logic [63:0] qid_acc;
    logic [31:0] qid_ver;
    logic [31:0] br_dec;
    logic [7:0]  q_type_upd;
    logic [31:0] q_ver_upd;
    logic [63:0] q_path_upd;

    logic        ev_valid;
    logic [3:0]  ev_code;
    logic [63:0] ev_value;
    logic [7:0]  ev_qt;
    logic [31:0] ev_qv;
    logic        done_valid;
    logic [3:0]  done_status;
    logic [3:0]  kind;
    frp_result_t ev_r;
    frp_result_t done_r;

    assign b         = msg.rx_byte;
    assign accept    = msg.valid && room;
    assign msg.ready = room;

    // byte count saturates at all ones
    assign bc_inc   = (&bc_reg) ? bc_reg : bc_reg + 32'd1;
    assign fbi_inc  = fbi_reg + 4'd1;
    assign byte_acc = acc_reg | (64'(b) << {fbi_reg[2:0], 3'b000});
    // qid layout: type[1] version[4] path[8]
    assign qid_acc  = acc_reg | (64'(b) << {fbi_reg[2:0] - 3'd5, 3'b000});
    assign qid_ver  = hqv_reg | (32'(b) << {fbi_reg[1:0] - 2'd1, 3'b000});
    assign br_dec   = (br_reg != 32'd0) ? br_reg - 32'd1 : br_reg;

    assign q_type_upd = (fbi_reg == 4'd0) ? b : hqt_reg;
    assign q_ver_upd  = (fbi_reg == 4'd0) ? 32'd0 : (fbi_reg < 4'd5) ? qid_ver : hqv_reg;
    assign q_path_upd = (fbi_reg < 4'd5) ? acc_reg : qid_acc;

    function automatic logic [3:0] body_phase(logic [7:0] ty);
        logic [3:0] ph;
        case (ty)
            TY_VERSION:         ph = PH_MSIZE;
            TY_ATTACH, TY_OPEN: ph = PH_QID;
            TY_ERROR:           ph = PH_STRLEN;
            TY_WALK:            ph = PH_NWQID;
            TY_READ, TY_WRITE:  ph = PH_COUNT;
            TY_CLUNK:           ph = PH_TAIL;
            default:            ph = PH_SKIP;
        endcase
        return ph;
    endfunction

    function automatic logic [3:0] final_status(logic [31:0] bc, logic [31:0] ds,
                                                logic [3:0] ph, logic [7:0] ty);
        logic [3:0] st;
        if (bc < 32'(HDR_LEN)) begin
            st = ST_SHORT;
        end
        else if (ds != bc || ds[31]) begin
            st = ST_SIZE;
        end
        else begin
            case (ph)
                PH_MSIZE:                st = ST_MSIZE;
                PH_STRLEN, PH_STRBYTES:  st = (ty == TY_VERSION) ? ST_VERSION : ST_ENAME;
                PH_QID:                  st = (ty == TY_ATTACH) ? ST_ATTACH_QID :
                                              (ty == TY_WALK)   ? ST_WALK_QID : ST_OPEN_QID;
                PH_NWQID:                st = ST_WALK_COUNT;
                PH_IOUNIT:               st = ST_IOUNIT;
                PH_COUNT:                st = (ty == TY_READ) ? ST_READ_COUNT : ST_WRITE_COUNT;
                PH_DATA:                 st = ST_READ_DATA;
                PH_SKIP:                 st = ST_UNKNOWN;
                default:                 st = ST_OK;
            endcase
        end
        return st;
    endfunction

    always_comb
    begin
        bc_next     = bc_reg;
        ds_next     = ds_reg;
        type_next   = type_reg;
        phase_next  = phase_reg;
        fbi_next    = fbi_reg;
        acc_next    = acc_reg;
        hqt_next    = hqt_reg;
        hqv_next    = hqv_reg;
        br_next     = br_reg;
        qr_next     = qr_reg;
        ev_valid    = 1'b0;
        ev_code     = EV_HEADER;
        ev_value    = '0;
        ev_qt       = '0;
        ev_qv       = '0;
        done_valid  = 1'b0;
        done_status = ST_OK;
        kind        = frp_kind_of(type_reg);

        if (accept)
        begin
            bc_next = bc_inc;
            if (bc_reg < 32'(HDR_LEN))
            begin
                case (bc_reg[2:0])
                    3'd0, 3'd1, 3'd2, 3'd3:
                        ds_next = ds_reg | (32'(b) << {bc_reg[1:0], 3'b000});
                    3'd4:
                        type_next = b;
                    3'd5:
                        acc_next = 64'(b);
                    default:
                    begin
                        // last header byte: tag complete
                        ev_valid   = 1'b1;
                        ev_code    = EV_HEADER;
                        ev_value   = {48'd0, b, acc_reg[7:0]};
                        phase_next = body_phase(type_reg);
                        fbi_next   = '0;
                        acc_next   = '0;
                    end
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_MSIZE:
                    begin
                        acc_next = byte_acc;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 4'(U32_LEN))
                        begin
                            ev_valid   = 1'b1;
                            ev_code    = EV_MSIZE;
                            ev_value   = byte_acc;
                            phase_next = PH_STRLEN;
                            fbi_next   = '0;
                            acc_next   = '0;
                        end
                    end
                    PH_STRLEN:
                    begin
                        acc_next = byte_acc;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 4'(U16_LEN))
                        begin
                            br_next    = {16'd0, byte_acc[15:0]};
                            ev_valid   = 1'b1;
                            ev_code    = EV_STRLEN;
                            ev_value   = {48'd0, byte_acc[15:0]};
                            phase_next = (byte_acc[15:0] != 16'd0) ? PH_STRBYTES : PH_TAIL;
                            fbi_next   = '0;
                            acc_next   = '0;
                        end
                    end
                    PH_STRBYTES, PH_DATA:
                    begin
                        ev_valid = 1'b1;
                        ev_code  = (phase_reg == PH_DATA) ? EV_DATABYTE : EV_STRBYTE;
                        ev_value = 64'(b);
                        br_next  = br_dec;
                        if (br_dec == 32'd0)
                        begin
                            phase_next = PH_TAIL;
                            fbi_next   = '0;
                            acc_next   = '0;
                        end
                    end
                    PH_QID:
                    begin
                        hqt_next = q_type_upd;
                        hqv_next = q_ver_upd;
                        acc_next = q_path_upd;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 4'(QID_LEN))
                        begin
                            ev_valid = 1'b1;
                            ev_code  = EV_QID;
                            ev_value = q_path_upd;
                            ev_qt    = q_type_upd;
                            ev_qv    = q_ver_upd;
                            fbi_next = '0;
                            acc_next = '0;
                            if (type_reg == TY_OPEN)
                            begin
                                phase_next = PH_IOUNIT;
                            end
                            else if (type_reg == TY_WALK && qr_reg > 16'd1)
                            begin
                                qr_next    = qr_reg - 16'd1;
                                phase_next = PH_QID;
                            end
                            else
                            begin
                                qr_next    = '0;
                                phase_next = PH_TAIL;
                            end
                        end
                    end
                    PH_NWQID:
                    begin
                        acc_next = byte_acc;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 4'(U16_LEN))
                        begin
                            qr_next    = byte_acc[15:0];
                            ev_valid   = 1'b1;
                            ev_code    = EV_NWQID;
                            ev_value   = {48'd0, byte_acc[15:0]};
                            phase_next = (byte_acc[15:0] != 16'd0) ? PH_QID : PH_TAIL;
                            fbi_next   = '0;
                            acc_next   = '0;
                        end
                    end
                    PH_IOUNIT:
                    begin
                        acc_next = byte_acc;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 4'(U32_LEN))
                        begin
                            ev_valid   = 1'b1;
                            ev_code    = EV_IOUNIT;
                            ev_value   = byte_acc;
                            phase_next = PH_TAIL;
                            fbi_next   = '0;
                            acc_next   = '0;
                        end
                    end
                    PH_COUNT:
                    begin
                        acc_next = byte_acc;
                        fbi_next = fbi_inc;
                        if (fbi_inc >= 4'(U32_LEN))
                        begin
                            br_next    = byte_acc[31:0];
                            ev_valid   = 1'b1;
                            ev_code    = EV_COUNT;
                            ev_value   = {32'd0, byte_acc[31:0]};
                            phase_next = (type_reg == TY_READ && byte_acc[31:0] != 32'd0)
                                         ? PH_DATA : PH_TAIL;
                            fbi_next   = '0;
                            acc_next   = '0;
                        end
                    end
                    default:
                    begin
                        // trailing bytes and unknown bodies are dropped
                    end
                endcase
            end

            kind = frp_kind_of(type_next);

            if (msg.end_of_message)
            begin
                done_valid  = 1'b1;
                done_status = final_status(bc_inc, ds_next, phase_next, type_next);
                bc_next     = '0;
                ds_next     = '0;
                type_next   = '0;
                phase_next  = PH_HDR;
                fbi_next    = '0;
                acc_next    = '0;
                hqt_next    = '0;
                hqv_next    = '0;
                br_next     = '0;
                qr_next     = '0;
            end
        end
    end

    always_comb
    begin
        ev_r   = '{event_res: ev_code, msg_kind: kind, value: ev_value, qid_type: ev_qt,
                   qid_version: ev_qv, status: ST_OK, last_of_run: !done_valid};
        done_r = '{event_res: EV_DONE, msg_kind: kind, value: {32'd0, bc_inc},
                   qid_type: 8'd0, qid_version: 32'd0, status: done_status,
                   last_of_run: 1'b1};
        push.cnt = {ev_valid && done_valid, ev_valid ^ done_valid};
        push.r0  = ev_valid ? ev_r : done_r;
        push.r1  = done_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg    <= '0;
            ds_reg    <= '0;
            type_reg  <= '0;
            phase_reg <= PH_HDR;
            fbi_reg   <= '0;
            acc_reg   <= '0;
            hqt_reg   <= '0;
            hqv_reg   <= '0;
            br_reg    <= '0;
            qr_reg    <= '0;
        end
        else
        begin
            bc_reg    <= bc_next;
            ds_reg    <= ds_next;
            type_reg  <= type_next;
            phase_reg <= phase_next;
            fbi_reg   <= fbi_next;
            acc_reg   <= acc_next;
            hqt_reg   <= hqt_next;
            hqv_reg   <= hqv_next;
            br_reg    <= br_next;
            qr_reg    <= qr_next;
        end
    end

    `FRP_ASSERT_NEXT(a_final_byte_clears, clk, rst_n, accept && msg.end_of_message, bc_reg == 32'd0 && phase_reg == PH_HDR, "parse state not cleared after final byte")
    `FRP_ASSERT_NOW(a_pair_only_on_final, clk, rst_n, push.cnt == 2'd2, accept && msg.end_of_message, "two results from a byte that is not final")
    `FRP_ASSERT_NOW(a_header_at_tag_end, clk, rst_n, ev_valid && ev_code == EV_HEADER, bc_reg == 32'(HDR_LEN - 1), "header event away from the last header byte")

endmodule

`default_nettype wire

[hw/rtl/frp_result_queue.sv]
// Small result queue between the parser and the event channel.
// Depends on frp_pkg, frp_event_if and the assertion macro header.
`default_nettype none
`include "file_protocol_reply_parser_assert.svh"

module frp_result_queue #(
    parameter int unsigned Depth = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire frp_pkg::frp_push_t push,
    output logic              room,
    frp_event_if.source       evt
);
    import frp_pkg::*;

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    frp_result_t entries [Depth];

    logic [PtrW-1:0] wp_reg, wp_next;
    logic [PtrW-1:0] rp_reg, rp_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [PtrW-1:0] wp_plus1;
    logic [PtrW-1:0] wp_plus2;
    logic            pop;
    frp_result_t     head;

    function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    // take a byte only while a full pair still fits
    assign room     = (count_reg <= CntW'(Depth - 2));
    assign pop      = evt.valid && evt.ready;
    assign wp_plus1 = ptr_inc(wp_reg);
    assign wp_plus2 = ptr_inc(wp_plus1);

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg + CntW'(push.cnt) - CntW'(pop);
        case (push.cnt)
            2'd1:    wp_next = wp_plus1;
            2'd2:    wp_next = wp_plus2;
            default: wp_next = wp_reg;
        endcase
        if (pop)
        begin
            rp_next = ptr_inc(rp_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            entries[wp_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            entries[wp_plus1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    assign head            = entries[rp_reg];
    assign evt.valid       = (count_reg != '0);
    assign evt.event_res   = head.event_res;
    assign evt.msg_kind    = head.msg_kind;
    assign evt.value       = head.value;
    assign evt.qid_type    = head.qid_type;
    assign evt.qid_version = head.qid_version;
    assign evt.status      = head.status;
    assign evt.last_of_run = head.last_of_run;

    `FRP_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CntW'(Depth), "result queue count above depth")
    `FRP_ASSERT_NOW(a_push_has_room, clk, rst_n, push.cnt != 2'd0, count_reg <= CntW'(Depth - 2), "push into a queue without room for a pair")
    `FRP_ASSERT_NEXT(a_pair_lands, clk, rst_n, push.cnt == 2'd2, count_reg >= CntW'(2), "pair push left fewer than two entries")

endmodule

`default_nettype wire

[hw/rtl/file_protocol_reply_parser.sv]
// Top level of the streaming 9P reply parser: parser plus result queue.
// Depends on frp_pkg, frp_byte_if, frp_event_if, frp_parser, frp_result_queue.
`default_nettype none

// Takes one reply byte per cycle on msg while msg.ready is high and reports header,
// body-field, string/data byte and done events on evt through a registered result
// queue. A byte yields at most two events (a field event plus the done event on the
// flagged last byte); the second one goes out after the first, absorbed by a
// QueueDepth-entry result queue. msg.ready stays high while the queue holds at
// most QueueDepth-2 results, so bytes keep flowing while results wait downstream.
// Events already sent are not retracted: discard them when the done status is not ok.
module file_protocol_reply_parser #(
    parameter int unsigned QueueDepth = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    frp_byte_if.sink  msg,
    frp_event_if.source evt
);
    import frp_pkg::*;

    frp_push_t push;
    logic      room;

    frp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .room  (room),
        .push  (push)
    );

    frp_result_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .evt   (evt)
    );

endmodule

`default_nettype wire
